### rtl/ragp_pkg.sv
// Package: widths, constants and shared types of the go-to-point regulator.
`default_nettype none
package ragp_pkg;
	localparam int CordicSteps = 16;
	localparam int StepW = 5;
	localparam int CordW = 32;
	localparam int ZW = 26;
	localparam int AngW = 16;

	localparam logic signed [AngW-1:0] Deg180 = 16'sd11520;
	localparam logic signed [AngW-1:0] Deg360 = 16'sd23040;
	localparam logic signed [AngW-1:0] SatAng = 16'sd4608;
	localparam logic signed [AngW-1:0] RotStop = 16'sd64;
	localparam logic signed [AngW-1:0] TurnDone = 16'sd128;
	localparam logic signed [AngW-1:0] PassLimit = 16'sd5760;
	localparam logic [CordW-1:0] SteerMin = 32'd19200;
	localparam logic [CordW-1:0] InvGain = 32'd652032874;
	localparam logic [12:0] SatLin = 13'd2560;

	localparam logic [2:0] CfgTargetX = 3'd0;
	localparam logic [2:0] CfgTargetY = 3'd1;
	localparam logic [2:0] CfgTargetHeading = 3'd2;
	localparam logic [2:0] CfgReverse = 3'd3;
	localparam logic [2:0] CfgMode = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CORDIC, ST_MUL, ST_SPEED, ST_DONE
	} state_t;

	typedef struct packed {
		logic kind;
		logic signed [23:0] pose_x;
		logic signed [23:0] pose_y;
		logic signed [14:0] pose_heading;
	} cmd_t;

	typedef struct packed {
		logic signed [12:0] linear_ref;
		logic signed [13:0] angular_ref;
		logic moving;
		logic go_phase;
	} res_t;

	function automatic logic [ZW-1:0] atan_lut(input logic [StepW-1:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0: v = 26'd2949120; 5'd1: v = 26'd1740967; 5'd2: v = 26'd919879;
			5'd3: v = 26'd466945; 5'd4: v = 26'd234379; 5'd5: v = 26'd117304;
			5'd6: v = 26'd58666; 5'd7: v = 26'd29335; 5'd8: v = 26'd14668;
			5'd9: v = 26'd7334; 5'd10: v = 26'd3667; 5'd11: v = 26'd1833;
			5'd12: v = 26'd917; 5'd13: v = 26'd458; 5'd14: v = 26'd229;
			5'd15: v = 26'd115; 5'd16: v = 26'd57; 5'd17: v = 26'd29;
			5'd18: v = 26'd14; 5'd19: v = 26'd7; 5'd20: v = 26'd4;
			5'd21: v = 26'd2; 5'd22: v = 26'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Wrap an angle (1/64 deg) known to lie in (-900, 900] deg into (-180, 180].
	function automatic logic signed [AngW:0] wrap_angle(input logic signed [AngW:0] v);
		logic signed [AngW:0] m;
		m = v;
		if (m > 17'(Deg180)) m = m - 17'(Deg360);
		if (m > 17'(Deg180)) m = m - 17'(Deg360);
		if (m <= -17'(Deg180)) m = m + 17'(Deg360);
		if (m <= -17'(Deg180)) m = m + 17'(Deg360);
		return m;
	endfunction

	function automatic logic signed [13:0] sat_ang(input logic signed [AngW:0] v);
		logic signed [13:0] r;
		if (v > 17'(SatAng)) r = 14'(SatAng);
		else if (v < -17'(SatAng)) r = -14'(SatAng);
		else r = 14'(v);
		return r;
	endfunction

	function automatic logic [AngW:0] abs17(input logic signed [AngW:0] v);
		return v[AngW] ? 17'(-v) : 17'(v);
	endfunction
endpackage
`default_nettype wire

### rtl/ragp_stream_if.sv
// Interface: valid/ready channel carrying a packed payload.
`default_nettype none
interface ragp_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/ragp_front.sv
// Front end: a two-entry queue toward the back end.
`default_nettype none
module ragp_front import ragp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire cmd_t in_data,
	output logic q_valid,
	input wire logic q_ready,
	output cmd_t q_data
);
	cmd_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	// Store beats in arrival order.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

	// Advance pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

### rtl/ragp_back.sv
// Back end: CORDIC vectoring, speed law and motion state, with output register.
`default_nettype none
module ragp_back import ragp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire cmd_t q_data,
	input wire logic signed [23:0] target_x,
	input wire logic signed [23:0] target_y,
	input wire logic signed [14:0] target_heading,
	input wire logic reverse_drive,
	input wire logic motion_mode,
	output logic out_valid,
	input wire logic out_ready,
	output res_t out_data
);
	state_t state_q, state_d;
	logic active_q, phase_q;
	cmd_t cmd_q;
	logic signed [CordW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [StepW-1:0] step_q;
	logic [63:0] prod_q;
	logic [CordW-1:0] r_q;
	logic [AngW:0] spd_q;
	logic signed [AngW:0] err_q;
	logic zero_q;
	res_t res_q;
	logic res_v_q;

	logic signed [24:0] dx, dy;
	logic signed [CordW-1:0] x0, y0, xs, ys;
	logic signed [ZW-1:0] z0, zr;
	logic signed [AngW:0] bearing, err_b, err_h;
	logic take, fire;

	assign q_ready = state_q == ST_IDLE && !res_v_q;
	assign take = q_valid && q_ready;
	assign out_valid = res_v_q;
	assign out_data = res_q;

	// Pre-rotate the offset into the right half plane.
	always_comb begin
		dx = 25'(target_x) - 25'(q_data.pose_x);
		dy = 25'(target_y) - 25'(q_data.pose_y);
		x0 = CordW'(dx) <<< 4;
		y0 = CordW'(dy) <<< 4;
		z0 = '0;
		if (dx < 0) begin
			if (dy >= 0) begin
				x0 = CordW'(dy) <<< 4; y0 = -(CordW'(dx) <<< 4); z0 = 26'sd5898240;
			end else begin
				x0 = -(CordW'(dy) <<< 4); y0 = CordW'(dx) <<< 4; z0 = -26'sd5898240;
			end
		end
	end

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign zr = z_q + 26'sd512;
	assign bearing = zero_q ? '0 : 17'(zr >>> 10);
	assign err_b = wrap_angle(bearing + (reverse_drive ? 17'(Deg180) : 17'sd0)
		- 17'(cmd_q.pose_heading));
	assign err_h = wrap_angle(17'(target_heading) - 17'(cmd_q.pose_heading));

	// Sequence one command through the shared CORDIC stage.
	always_comb begin
		state_d = state_q;
		fire = 1'b0;
		unique case (state_q)
			ST_IDLE: if (take) begin
				if (!q_data.kind && active_q && motion_mode) state_d = ST_CORDIC;
				else state_d = ST_DONE;
			end
			ST_CORDIC: if (step_q == StepW'(CordicSteps - 1)) state_d = ST_MUL;
			ST_MUL: state_d = ST_SPEED;
			ST_SPEED: state_d = ST_DONE;
			ST_DONE: begin
				fire = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Datapath: capture, iterate, scale.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= q_data;
			x_q <= x0; y_q <= y0; z_q <= z0;
			step_q <= '0;
			zero_q <= dx == 0 && dy == 0;
		end else if (state_q == ST_CORDIC) begin
			if (y_q > 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + ZW'(atan_lut(step_q));
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - ZW'(atan_lut(step_q));
			end
			step_q <= step_q + 1'b1;
		end else if (state_q == ST_MUL) begin
			prod_q <= 64'(x_q) * 64'(InvGain);
			err_q <= err_b;
		end else if (state_q == ST_SPEED) begin
			r_q <= zero_q ? '0 : prod_q[61:30];
			// (2r+12)/25 saturated at 2560: any r above 32000 already reaches the limit
			if (zero_q) spd_q <= 17'd0;
			else if (prod_q[63:30] > 34'd32000) spd_q <= 17'(SatLin);
			else spd_q <= 17'(((40'(prod_q[63:30]) * 2 + 40'd12) * 40'd671089) >> 24);
		end
	end

	// Form the result and update motion state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q <= 1'b0;
			res_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (res_v_q && out_ready) res_v_q <= 1'b0;
			if (fire) begin
				res_v_q <= 1'b1;
				res_q.linear_ref <= '0;
				res_q.angular_ref <= '0;
				res_q.go_phase <= phase_q;
				res_q.moving <= active_q;
				if (cmd_q.kind) begin
					active_q <= 1'b1; phase_q <= 1'b0;
					res_q.moving <= 1'b1; res_q.go_phase <= 1'b0;
				end else if (active_q) begin
					if (!motion_mode) begin
						res_q.go_phase <= 1'b0;
						if (abs17(err_h) < 17'(RotStop)) begin
							active_q <= 1'b0; res_q.moving <= 1'b0;
						end else res_q.angular_ref <= sat_ang(err_h);
					end else if (!phase_q) begin
						res_q.angular_ref <= sat_ang(err_q);
						if (abs17(err_q) < 17'(TurnDone)) phase_q <= 1'b1;
					end else if (abs17(err_q) > 17'(PassLimit)) begin
						phase_q <= 1'b0; active_q <= 1'b0; res_q.moving <= 1'b0;
					end else begin
						res_q.linear_ref <= reverse_drive ? -13'(spd_q) : 13'(spd_q);
						res_q.angular_ref <= r_q > SteerMin ? sat_ang(err_q) : '0;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/rotate_and_go_to_point_regulator.sv
// Top level: configuration registers, front queue and back end.
//  channel | dir | payload
//  cmd     | in  | kind, pose_x, pose_y, pose_heading
//  res     | out | linear_ref, angular_ref, moving, go_phase
//  cfg     | in  | cfg_we, cfg_index, cfg_data (24 bit)
// A go-to-point tick runs 16 CORDIC iterations, then the multiply, speed and result steps;
// other items go straight to the result; no new item is taken until the result is taken.
// arst_n clears motion state, queue and output register.
// The queue takes beats while the back end works or its result waits.
`default_nettype none
module rotate_and_go_to_point_regulator import ragp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ragp_stream_if.sink cmd,
	ragp_stream_if.source res,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [23:0] cfg_data
);
	logic signed [23:0] tx_q, ty_q;
	logic signed [14:0] th_q;
	logic rev_q, mode_q;
	logic qv, qr;
	cmd_t qd;
	res_t rd;

	// Hold configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= '0; ty_q <= '0; th_q <= '0; rev_q <= 1'b0; mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgTargetX: tx_q <= cfg_data;
				CfgTargetY: ty_q <= cfg_data;
				CfgTargetHeading: th_q <= cfg_data[14:0];
				CfgReverse: rev_q <= cfg_data[0];
				CfgMode: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ragp_front u_front (
		.clk, .arst_n,
		.in_valid(cmd.valid), .in_ready(cmd.ready), .in_data(cmd_t'(cmd.data)),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	ragp_back u_back (
		.clk, .arst_n,
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.target_x(tx_q), .target_y(ty_q), .target_heading(th_q),
		.reverse_drive(rev_q), .motion_mode(mode_q),
		.out_valid(res.valid), .out_ready(res.ready), .out_data(rd)
	);

	assign res.data = rd;
endmodule
`default_nettype wire

### rtl/ragp_checker.sv
// Checker: port-level properties of the regulator, bound to the top level.
`default_nettype none
module ragp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic [28:0] res_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("res dropped");
	a_lin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($signed(res_data[28:16]) <= 13'sd2560 &&
		$signed(res_data[28:16]) >= -13'sd2560)) else $error("linear out of range");
	a_ang: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($signed(res_data[15:2]) <= 14'sd4608 &&
		$signed(res_data[15:2]) >= -14'sd4608)) else $error("angular out of range");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data[1] |-> res_data[28:16] == 13'd0)
		else $error("linear while stopped");
endmodule

bind rotate_and_go_to_point_regulator ragp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.res_data(res.data)
);
`default_nettype wire

### dv/rotate_and_go_to_point_regulator_tb.sv
// Testbench for the go-to-point regulator: predicted responses checked beat by beat.
`timescale 1ns / 100ps
module rotate_and_go_to_point_regulator_tb;
	import ragp_pkg::*;

	localparam logic KindTick = 1'b0;
	localparam logic KindStart = 1'b1;
	localparam int CycleLimit = 400000;
	localparam int DrainWait = 30;
	localparam int HoldCycles = 300;

	// Regulator predictor: live register copy, motion state and expected responses
	class regulator_scoreboard;
		logic signed [23:0] tgt_x, tgt_y;
		logic signed [14:0] tgt_heading;
		bit reverse, go_mode, active, translating;
		res_t expected_q[$];
		int errors, checked;
		longint atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
			4, 2, 1, 0};

		function void set_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				CfgTargetX: tgt_x = val;
				CfgTargetY: tgt_y = val;
				CfgTargetHeading: tgt_heading = val[14:0];
				CfgReverse: reverse = val[0];
				CfgMode: go_mode = val[0];
				default: ;
			endcase
		endfunction

		function longint wrap(longint v);
			longint m;
			m = v % 23040;
			if (m > 11520) m -= 23040;
			if (m <= -11520) m += 23040;
			return m;
		endfunction

		function longint clip(longint v, longint lim);
			return v > lim ? lim : (v < -lim ? -lim : v);
		endfunction

		// Vectoring rotation: bearing in 1/64 deg, range in 1/256 mm
		function void vector(longint dx, longint dy, output longint bearing,
				output longint range_q8);
			longint x, y, z, t, xs, ys;
			x = dx * 16;
			y = dy * 16;
			z = 0;
			bearing = 0;
			range_q8 = 0;
			if (dx == 0 && dy == 0) return;
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = 90 * 65536;
				end else begin
					x = -y; y = t; z = -90 * 65536;
				end
			end
			for (int i = 0; i < CordicSteps && i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += atan_steps[i];
				end else begin
					x -= ys; y += xs; z -= atan_steps[i];
				end
			end
			bearing = (z + 512) >>> 10;
			range_q8 = (x * 64'd652032874) >>> 30;
		endfunction

		function void note_cmd(cmd_t c);
			longint lin, ang, err, brg, rng, spd;
			res_t e;
			bit used;
			lin = 0;
			ang = 0;
			used = translating;
			if (c.kind == KindStart) begin
				active = 1;
				translating = 0;
				used = 0;
			end else if (active) begin
				if (!go_mode) begin
					err = wrap(longint'(tgt_heading) - longint'(c.pose_heading));
					used = 0;
					ang = clip(err, 4608);
					if (err < 64 && err > -64) begin
						ang = 0;
						active = 0;
					end
				end else begin
					vector(longint'(tgt_x) - longint'(c.pose_x),
						longint'(tgt_y) - longint'(c.pose_y), brg, rng);
					err = wrap(brg + (reverse ? 11520 : 0) - longint'(c.pose_heading));
					if (!translating) begin
						ang = clip(err, 4608);
						if (err < 128 && err > -128) translating = 1;
					end else if (err > 5760 || err < -5760) begin
						translating = 0;
						active = 0;
					end else begin
						spd = clip((2 * rng + 12) / 25, 2560);
						lin = reverse ? -spd : spd;
						ang = rng > 19200 ? clip(err, 4608) : 0;
					end
				end
			end
			e.linear_ref = 13'(lin);
			e.angular_ref = 14'(ang);
			e.moving = active;
			e.go_phase = used;
			expected_q.push_back(e);
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
		endtask

		task check_res(res_t r);
			res_t e;
			checked++;
			if (expected_q.size() == 0) begin
				report("unexpected beat, linear_ref", r.linear_ref, 0);
				return;
			end
			e = expected_q.pop_front();
			if (r.linear_ref !== e.linear_ref) report("linear_ref", r.linear_ref, e.linear_ref);
			if (r.angular_ref !== e.angular_ref)
				report("angular_ref", r.angular_ref, e.angular_ref);
			if (r.moving !== e.moving) report("moving", r.moving, e.moving);
			if (r.go_phase !== e.go_phase) report("go_phase", r.go_phase, e.go_phase);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	ragp_stream_if #(.W($bits(cmd_t))) cmd_if ();
	ragp_stream_if #(.W($bits(res_t))) res_if ();

	regulator_scoreboard sb = new();
	bit steady;
	bit hold_req;
	int sent;
	int phases;
	longint cycles;

	rotate_and_go_to_point_regulator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("rotate_and_go_to_point_regulator: mismatch");
			$finish;
		end
	end

	// Accept result beats with random stalls and one long hold-off
	initial begin
		int n;
		bit held;
		held = 0;
		res_if.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				res_if.ready <= 0;
				repeat (HoldCycles) @(posedge clk);
				held = 1;
			end
			n = steady ? 0 : $urandom_range(0, 4);
			if (n > 0) begin
				res_if.ready <= 0;
				repeat (n) @(posedge clk);
			end
			res_if.ready <= 1;
			do @(posedge clk); while (!res_if.valid);
			sb.check_res(res_if.data);
		end
	end

	task send(cmd_t c);
		int n;
		n = steady ? 0 : $urandom_range(0, 4);
		if (n > 0) begin
			cmd_if.valid <= 0;
			repeat (n) @(posedge clk);
		end
		cmd_if.valid <= 1;
		cmd_if.data <= c;
		do @(posedge clk); while (!cmd_if.ready);
		sb.note_cmd(c);
		sent++;
	endtask

	task start_motion();
		cmd_t c;
		c = '0;
		c.kind = KindStart;
		send(c);
	endtask

	task tick(longint x, longint y, longint h);
		cmd_t c;
		c.kind = KindTick;
		c.pose_x = 24'(x);
		c.pose_y = 24'(y);
		c.pose_heading = 15'(h);
		send(c);
	endtask

	// Drop valid and hold until every response is back and the back end is idle
	task drain();
		cmd_if.valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task configure(longint tx, longint ty, longint th, bit rev, bit mode);
		logic [23:0] vals[5];
		vals[CfgTargetX] = 24'(tx);
		vals[CfgTargetY] = 24'(ty);
		vals[CfgTargetHeading] = 24'(th);
		vals[CfgReverse] = 24'(rev);
		vals[CfgMode] = 24'(mode);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(3'(i), vals[i]);
		end
		cfg_we <= 0;
	endtask

	function longint heading_of(longint v);
		longint w;
		w = sb.wrap(v);
		return w == 11520 ? -11520 : w;
	endfunction

	function longint clamp24(longint v);
		return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
	endfunction

	function longint pick_coord();
		case ($urandom_range(0, 5))
			0: return 8388607;
			1: return -8388608;
			2: return longint'($urandom_range(0, 16777215)) - 8388608;
			default: return longint'($urandom_range(0, 100000)) - 50000;
		endcase
	endfunction

	function longint pick_offset();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return longint'($urandom_range(0, 3000)) - 1500;
			2: return longint'($urandom_range(0, 200000)) - 100000;
			default: return longint'($urandom_range(0, 8000000)) - 4000000;
		endcase
	endfunction

	// Heading toward the goal from a pose, plus a jitter
	function longint aim(longint px, longint py, longint jitter);
		longint brg, rng;
		sb.vector(longint'(sb.tgt_x) - px, longint'(sb.tgt_y) - py, brg, rng);
		return heading_of(brg + (sb.reverse ? 11520 : 0) + jitter);
	endfunction

	task random_phase();
		longint px, py, h;
		int len;
		cmd_t c;
		configure(pick_coord(), pick_coord(), longint'($urandom_range(0, 23039)) - 11520,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		len = $urandom_range(5, 30);
		start_motion();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				// noise beat over the full field widths
				c = cmd_t'({$urandom, $urandom});
				send(c);
			end else begin
				px = clamp24(longint'(sb.tgt_x) - pick_offset());
				py = clamp24(longint'(sb.tgt_y) - pick_offset());
				if (!sb.go_mode)
					h = heading_of(longint'(sb.tgt_heading) +
						longint'($urandom_range(0, 400)) - 200);
				else if ($urandom_range(0, 9) == 0)
					h = aim(px, py, longint'($urandom_range(0, 14000)) - 7000);
				else
					h = aim(px, py, longint'($urandom_range(0, 300)) - 150);
				if ($urandom_range(0, 15) == 0) h = longint'($urandom_range(0, 23039)) - 11520;
				tick(px, py, h);
			end
			if (!sb.active && $urandom_range(0, 2) == 0) start_motion();
		end
	endtask

	initial begin
		cmd_if.valid = 0;
		cmd_if.data = '0;
		steady = 0;
		hold_req = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Rotate mode: idle tick, saturation both ways, stop band, wrap
		tick(0, 0, 0);
		start_motion();
		tick(0, 0, 11519);
		tick(0, 0, -11520);
		tick(0, 0, 4700);
		tick(0, 0, -4700);
		tick(0, 0, 63);
		start_motion();
		tick(0, 0, 0);
		drain();
		configure(0, 0, -11520, 0, 0);
		start_motion();
		tick(8388607, -8388608, 11519);
		tick(0, 0, 16383);
		drain();

		// Go to point: extreme offset, translate, near goal, overshoot
		configure(8388607, -8388608, 0, 0, 1);
		start_motion();
		tick(-8388608, 8388607, 0);
		tick(-8388608, 8388607, aim(-8388608, 8388607, 0));
		tick(-8388608, 8388607, aim(-8388608, 8388607, 20));
		tick(8388600, -8388600, aim(8388600, -8388600, 0));
		tick(0, 0, aim(0, 0, 6000));
		drain();

		// Reverse drive with the robot on the goal
		configure(1000, -1000, 0, 1, 1);
		start_motion();
		tick(1000, -1000, -11520);
		tick(1000, -1000, 0);
		tick(0, 0, aim(0, 0, 0));
		tick(0, 0, aim(0, 0, -30));
		drain();

		// Random phases; one long receiver hold-off while beats keep coming
		phases = 0;
		while (sent < 1250) begin
			steady = ($urandom_range(0, 4) == 0);
			if (phases == 3) hold_req = 1;
			random_phase();
			drain();
			phases++;
		end

		$display("Covered %0d command beats over %0d random phases, %0d responses checked.",
			sent, phases, sb.checked);
		$display("Both modes, reverse drive, stop bands and a long output stall exercised.");
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("rotate_and_go_to_point_regulator: match");
		else
			$display("rotate_and_go_to_point_regulator: mismatch");
		$finish;
	end
endmodule
